// ----- rtl/ssv_pkg.sv -----
package ssv_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int SAMPLE_W     = 32;
    localparam int SCALED_W     = 31;
    localparam int SUM_W        = SAMPLE_W + CNT_W - 1;
    localparam int SQ_W         = 2 * SAMPLE_W + CNT_W - 1;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic              acc_clr;
        logic              acc_sum;
        logic              acc_sq;
        logic              div_start;
        logic              div_var;
        logic              mean_ld;
        logic              sqrt_start;
        logic              thr_ld;
        logic              out_ld;
        logic              out_last;
        logic              out_ovf;
        logic [CNT_W-1:0]  n;
    } ssv_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } ssv_status_t;

endpackage

// ----- rtl/ssv_ram.sv -----
module ssv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ssv_dp.sv -----
module ssv_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ssv_pkg::ssv_cmd_t                  cmd,
    output ssv_pkg::ssv_status_t               status,
    input  logic signed [ssv_pkg::SAMPLE_W-1:0] s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ssv_pkg::SCALED_W-1:0]       m_scaled,
    output logic                               m_end_of_run,
    output logic                               m_overflowed
);
    import ssv_pkg::*;

    localparam int DC_W   = $clog2(SQ_W + 1);
    localparam int ROOT_W = SAMPLE_W;
    localparam int SR_W   = ROOT_W + 2;
    localparam int SC_W   = $clog2(ROOT_W + 1);
    localparam int THR_W  = SAMPLE_W + 3;
    localparam int RES_W  = THR_W + 1;

    logic [SAMPLE_W-1:0] rdata;

    logic sum_v_reg, sqa_v_reg, sqb_v_reg, sqc_v_reg;
    logic signed [SUM_W-1:0] sum_acc_reg;
    logic [SQ_W-1:0]         sq_acc_reg;
    logic [SAMPLE_W-1:0]     a_reg;
    logic [2*SAMPLE_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] mean_reg;

    logic [DC_W-1:0]   div_cnt_reg;
    logic [SQ_W-1:0]   dq_reg;
    logic [CNT_W-1:0]  rem_reg;

    logic [SC_W-1:0]   sq_cnt_reg;
    logic [2*ROOT_W-1:0] x_reg;
    logic [SR_W-1:0]   srem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic signed [THR_W-1:0] thr_reg;

    logic                m_valid_reg;
    logic [SCALED_W-1:0] m_scaled_reg;
    logic                m_last_reg;
    logic                m_ovf_reg;

    logic signed [SAMPLE_W:0] dev;
    logic [SAMPLE_W:0]        dev_abs;
    logic                     sum_neg;
    logic [SUM_W-1:0]         sum_mag;
    logic [CNT_W:0]           div_try;
    logic                     div_ge;
    logic [SUM_W-1:0]         q_adj;
    logic [SUM_W-1:0]         mean_full;
    logic [SR_W+1:0]          srem_sh;
    logic [SR_W+1:0]          trial;
    logic                     sq_ge;
    logic signed [RES_W-1:0]  res;
    logic [SCALED_W-1:0]      res_clamp;

    ssv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (cmd.addr),
        .wdata (s_sample),
        .re    (cmd.rd_en),
        .raddr (cmd.addr),
        .rdata (rdata)
    );

    always_comb begin
        dev     = $signed({rdata[SAMPLE_W-1], rdata}) - $signed({mean_reg[SAMPLE_W-1], mean_reg});
        dev_abs = dev[SAMPLE_W] ? (SAMPLE_W + 1)'(-dev) : (SAMPLE_W + 1)'(dev);

        sum_neg = sum_acc_reg[SUM_W-1];
        sum_mag = sum_neg ? SUM_W'(-sum_acc_reg) : SUM_W'(sum_acc_reg);

        div_try = {rem_reg, dq_reg[SQ_W-1]};
        div_ge  = div_try >= {1'b0, cmd.n};

        q_adj     = dq_reg[SUM_W-1:0] + SUM_W'(rem_reg != '0);
        mean_full = sum_neg ? SUM_W'(-q_adj) : dq_reg[SUM_W-1:0];

        srem_sh = {srem_reg, x_reg[2*ROOT_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        sq_ge   = srem_sh >= trial;

        res = $signed({{(RES_W - SAMPLE_W){rdata[SAMPLE_W-1]}}, rdata})
            - $signed({thr_reg[THR_W-1], thr_reg});
        if (res[RES_W-1]) begin
            res_clamp = '0;
        end else if (res[RES_W-2:SCALED_W] != '0) begin
            res_clamp = '1;
        end else begin
            res_clamp = res[SCALED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_v_reg   <= 1'b0;
            sqa_v_reg   <= 1'b0;
            sqb_v_reg   <= 1'b0;
            sqc_v_reg   <= 1'b0;
            div_cnt_reg <= '0;
            sq_cnt_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_v_reg <= cmd.acc_sum;
            sqa_v_reg <= cmd.acc_sq;
            sqb_v_reg <= sqa_v_reg;
            sqc_v_reg <= sqb_v_reg;
            if (cmd.div_start) begin
                div_cnt_reg <= DC_W'(SQ_W);
            end else if (div_cnt_reg != '0) begin
                div_cnt_reg <= div_cnt_reg - DC_W'(1);
            end
            if (cmd.sqrt_start) begin
                sq_cnt_reg <= SC_W'(ROOT_W);
            end else if (sq_cnt_reg != '0) begin
                sq_cnt_reg <= sq_cnt_reg - SC_W'(1);
            end
            if (cmd.out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            sum_acc_reg <= '0;
            sq_acc_reg  <= '0;
        end else begin
            if (sum_v_reg) begin
                sum_acc_reg <= sum_acc_reg + SUM_W'($signed(rdata));
            end
            if (sqc_v_reg) begin
                sq_acc_reg <= sq_acc_reg + SQ_W'(prod_reg);
            end
        end
        if (sqa_v_reg) begin
            a_reg <= dev_abs[SAMPLE_W-1:0];
        end
        if (sqb_v_reg) begin
            prod_reg <= a_reg * a_reg;
        end

        if (cmd.div_start) begin
            dq_reg  <= cmd.div_var ? sq_acc_reg : SQ_W'(sum_mag);
            rem_reg <= '0;
        end else if (div_cnt_reg != '0) begin
            dq_reg  <= {dq_reg[SQ_W-2:0], div_ge};
            rem_reg <= div_ge ? CNT_W'(div_try - {1'b0, cmd.n}) : div_try[CNT_W-1:0];
        end
        if (cmd.mean_ld) begin
            mean_reg <= mean_full[SAMPLE_W-1:0];
        end

        if (cmd.sqrt_start) begin
            x_reg    <= dq_reg[2*ROOT_W-1:0];
            srem_reg <= '0;
            root_reg <= '0;
        end else if (sq_cnt_reg != '0) begin
            x_reg    <= {x_reg[2*ROOT_W-3:0], 2'b00};
            srem_reg <= sq_ge ? SR_W'(srem_sh - trial) : SR_W'(srem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
        end
        if (cmd.thr_ld) begin
            thr_reg <= $signed({{(THR_W - SAMPLE_W){mean_reg[SAMPLE_W-1]}}, mean_reg})
                     - $signed({{(THR_W - ROOT_W - 1){1'b0}}, root_reg, 1'b0});
        end

        if (cmd.out_ld) begin
            m_scaled_reg <= res_clamp;
            m_last_reg   <= cmd.out_last;
            m_ovf_reg    <= cmd.out_ovf;
        end
    end

    assign status.pipe_busy = sum_v_reg | sqa_v_reg | sqb_v_reg | sqc_v_reg;
    assign status.div_busy  = div_cnt_reg != '0;
    assign status.sqrt_busy = sq_cnt_reg != '0;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_scaled     = m_scaled_reg;
    assign m_end_of_run = m_last_reg;
    assign m_overflowed = m_ovf_reg;

endmodule

// ----- rtl/ssv_ctrl.sv -----
module ssv_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_is_last,
    input  ssv_pkg::ssv_status_t status,
    output ssv_pkg::ssv_cmd_t    cmd
);
    import ssv_pkg::*;

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_SUM      = 4'd1;
    localparam logic [3:0] S_SUM_WAIT = 4'd2;
    localparam logic [3:0] S_DIVM     = 4'd3;
    localparam logic [3:0] S_SQ       = 4'd4;
    localparam logic [3:0] S_SQ_WAIT  = 4'd5;
    localparam logic [3:0] S_DIVV     = 4'd6;
    localparam logic [3:0] S_SQRT     = 4'd7;
    localparam logic [3:0] S_THR      = 4'd8;
    localparam logic [3:0] S_EMIT_RD  = 4'd9;
    localparam logic [3:0] S_EMIT_WR  = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              at_last;
    logic              accept;
    logic              has_room;

    assign accept   = s_valid && s_ready;
    assign has_room = count_reg < CNT_W'(MAX_ELEMENTS);
    assign at_last  = CNT_W'(idx_reg) == (count_reg - CNT_W'(1));
    assign s_ready  = state_reg == S_LOAD;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.addr   = idx_reg;
        cmd.n      = count_reg;
        cmd.out_last = at_last;
        cmd.out_ovf  = ovf_reg;

        unique case (state_reg)
            S_LOAD: begin
                cmd.acc_clr = 1'b1;
                cmd.addr    = count_reg[ADDR_W-1:0];
                idx_next    = '0;
                if (accept) begin
                    if (has_room) begin
                        cmd.wr_en  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_is_last) begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM: begin
                cmd.rd_en   = 1'b1;
                cmd.acc_sum = 1'b1;
                if (at_last) begin
                    idx_next   = '0;
                    state_next = S_SUM_WAIT;
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_SUM_WAIT: begin
                if (!status.pipe_busy) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVM;
                end
            end
            S_DIVM: begin
                if (!status.div_busy) begin
                    cmd.mean_ld = 1'b1;
                    state_next  = S_SQ;
                end
            end
            S_SQ: begin
                cmd.rd_en  = 1'b1;
                cmd.acc_sq = 1'b1;
                if (at_last) begin
                    idx_next   = '0;
                    state_next = S_SQ_WAIT;
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_SQ_WAIT: begin
                if (!status.pipe_busy) begin
                    cmd.div_start = 1'b1;
                    cmd.div_var   = 1'b1;
                    state_next    = S_DIVV;
                end
            end
            S_DIVV: begin
                if (!status.div_busy) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                end
            end
            S_SQRT: begin
                if (!status.sqrt_busy) begin
                    state_next = S_THR;
                end
            end
            S_THR: begin
                cmd.thr_ld = 1'b1;
                state_next = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (status.out_free) begin
                    cmd.out_ld = 1'b1;
                    if (at_last) begin
                        idx_next   = '0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_out_ld_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> status.out_free)
        else $error("result loaded while output register still full");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> status.div_busy)
        else $error("divider did not start");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_is_last) |=> (state_reg == S_SUM) && (count_reg != '0))
        else $error("closing transfer did not start an empty-free sum pass");
`endif

endmodule

// ----- rtl/sigma_scale_vector.sv -----
// Sequence: n loads at one transfer per cycle; after the closing transfer the block makes
//   two passes of n reads, two 70-step divisions and a 32-step square root, then emits
//   n results. No new samples are accepted until the last result is loaded.
// Output: a registered store read per result, then a load that waits for a free output.
// Reset: synchronous, active low; clears control state. The sample store is not cleared.
module sigma_scale_vector (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [ssv_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                               s_is_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ssv_pkg::SCALED_W-1:0]       m_scaled,
    output logic                               m_end_of_run,
    output logic                               m_overflowed
);
    import ssv_pkg::*;

    ssv_cmd_t    cmd;
    ssv_status_t status;

    ssv_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_is_last (s_is_last),
        .status    (status),
        .cmd       (cmd)
    );

    ssv_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scaled     (m_scaled),
        .m_end_of_run (m_end_of_run),
        .m_overflowed (m_overflowed)
    );

endmodule

// ----- sim/sigma_scale_vector_tb.sv -----
`timescale 1ns / 1ps

module sigma_scale_vector_tb;

    import ssv_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 40;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam longint SCALED_CEIL = 64'h0000_0000_7FFF_FFFF;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EXTREME
    } spread_t;

    typedef struct {
        logic [SCALED_W-1:0] scaled;
        logic                end_of_run;
        logic                overflowed;
    } scaled_result_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample  = '0;
    logic                       s_is_last = 1'b0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic [SCALED_W-1:0]        m_scaled;
    logic                       m_end_of_run;
    logic                       m_overflowed;

    logic signed [SAMPLE_W-1:0] held_samples[$];
    logic signed [SAMPLE_W-1:0] pending_q[$];
    scaled_result_t             expected_q[$];
    logic                       samples_dropped = 1'b0;

    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  cycle_count    = 0;
    int  stall_left     = 0;
    bit  src_idle       = 1'b0;
    bit  sink_stalls    = 1'b0;

    sigma_scale_vector dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scaled     (m_scaled),
        .m_end_of_run (m_end_of_run),
        .m_overflowed (m_overflowed)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    task automatic add_pending(input logic signed [SAMPLE_W-1:0] value);
        pending_q.insert(pending_q.size(), value);
    endtask

    // mean, population std and the clamped offsets for the closed vector
    task automatic predict_scaled_run();
        int                n;
        longint            sum_acc;
        longint            mean;
        longint            dev;
        longint            thr;
        longint            r;
        longint unsigned   mag;
        longint unsigned   variance;
        longint unsigned   sd;
        longint unsigned   trial;
        logic [127:0]      sq;
        logic [127:0]      sq_acc;
        logic [127:0]      var_wide;
        scaled_result_t    res;
        n = held_samples.size();
        sum_acc = 0;
        sq_acc = '0;
        for (int i = 0; i < n; i++) begin
            sum_acc = sum_acc + longint'(held_samples[i]);
        end
        mean = sum_acc / n;
        if ((sum_acc % n) != 0 && sum_acc < 0) begin
            mean = mean - 1;
        end
        for (int i = 0; i < n; i++) begin
            dev = longint'(held_samples[i]) - mean;
            mag = (dev < 0) ? -dev : dev;
            sq = {64'd0, mag} * {64'd0, mag};
            sq_acc = sq_acc + sq;
        end
        var_wide = sq_acc / 128'(n);
        variance = var_wide[63:0];
        sd = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = sd | (64'd1 << b);
            if (trial * trial <= variance) begin
                sd = trial;
            end
        end
        thr = mean - 2 * $signed(sd);
        for (int i = 0; i < n; i++) begin
            r = longint'(held_samples[i]) - thr;
            if (r < 0) begin
                r = 0;
            end
            if (r > SCALED_CEIL) begin
                r = SCALED_CEIL;
            end
            res.scaled     = r[SCALED_W-1:0];
            res.end_of_run = (i == n - 1);
            res.overflowed = samples_dropped;
            expected_q.insert(expected_q.size(), res);
        end
        held_samples.delete();
        samples_dropped = 1'b0;
    endtask

    task automatic record_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        if (held_samples.size() < MAX_ELEMENTS) begin
            held_samples.insert(held_samples.size(), value);
        end else begin
            samples_dropped = 1'b1;
        end
        if (last) begin
            predict_scaled_run();
        end
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_sample  <= value;
        s_is_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        record_sample(value, last);
    endtask

    task automatic send_pending(input int close_at);
        for (int i = 0; i < pending_q.size(); i++) begin
            send_sample(pending_q[i], i == close_at);
        end
        pending_q.delete();
    endtask

    function automatic logic signed [SAMPLE_W-1:0] make_sample(input spread_t spread,
                                                               input int base);
        int pick;
        if ($urandom_range(0, 19) == 0) begin
            return $urandom;
        end
        case (spread)
            SPREAD_FULL: begin
                return $urandom;
            end
            SPREAD_NARROW: begin
                return base + $urandom_range(0, 4000) - 2000;
            end
            default: begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: return SAMPLE_MIN;
                    1: return SAMPLE_MAX;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    task automatic send_random_vector(input int len);
        spread_t spread;
        int      base;
        spread = spread_t'($urandom_range(0, 2));
        base   = int'($urandom) >>> 1;
        for (int i = 0; i < len; i++) begin
            add_pending(make_sample(spread, base));
        end
        send_pending(len - 1);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        src_idle    = 1'b1;
        sink_stalls = 1'b1;
        pending_q = '{SAMPLE_MAX};
        send_pending(0);
        pending_q = '{SAMPLE_MIN};
        send_pending(0);
        // wide spread, both results saturate high
        pending_q = '{SAMPLE_MIN, SAMPLE_MAX};
        send_pending(1);
        // outlier well below mean - 2*std clamps to zero
        pending_q = '{-1000, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_pending(9);
        pending_q = '{32'sh0001_0000, 32'shFFFF_0000, 32'sh5555_5555,
                      32'shAAAA_AAAA, 0, -1, 1};
        send_pending(6);
    endtask

    task automatic test_full_store();
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            add_pending($urandom);
        end
        send_pending(MAX_ELEMENTS - 1);
    endtask

    task automatic test_overflow();
        // extra samples dropped, then a closing transfer that is itself dropped
        for (int i = 0; i < MAX_ELEMENTS + 6; i++) begin
            add_pending(int'($urandom) >>> 4);
        end
        send_pending(MAX_ELEMENTS + 5);
        for (int i = 0; i < MAX_ELEMENTS + 1; i++) begin
            add_pending($urandom_range(0, 100000));
        end
        send_pending(MAX_ELEMENTS);
        send_random_vector(3);
    endtask

    task automatic test_drain_pause();
        send_random_vector(5);
        s_valid <= 1'b0;
        wait_drained();
        send_random_vector(8);
    endtask

    task automatic test_back_to_back();
        src_idle    = 1'b0;
        sink_stalls = 1'b0;
        send_random_vector(12);
        send_random_vector(1);
        send_random_vector(30);
    endtask

    task automatic test_random_vectors();
        int target;
        int r;
        int len;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            src_idle    = ($urandom_range(0, 4) != 0);
            sink_stalls = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = $urandom_range(1, 12);
            end else if (r < 92) begin
                len = $urandom_range(13, MAX_ELEMENTS);
            end else begin
                len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 8);
            end
            if (len > target - items_sent) begin
                len = target - items_sent;
            end
            send_random_vector(len);
        end
    endtask

    always @(posedge aclk) begin
        if (!sink_stalls) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            stall_left = pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        scaled_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected transfer: expected none, actual scaled %0d eor %0b ovf %0b",
                         $time, m_scaled, m_end_of_run, m_overflowed);
            end else begin
                want = expected_q.pop_front();
                if (m_scaled !== want.scaled) begin
                    mismatch_count++;
                    $display("%0t: scaled: expected %0d, actual %0d",
                             $time, want.scaled, m_scaled);
                end
                if (m_end_of_run !== want.end_of_run) begin
                    mismatch_count++;
                    $display("%0t: end_of_run: expected %0b, actual %0b",
                             $time, want.end_of_run, m_end_of_run);
                end
                if (m_overflowed !== want.overflowed) begin
                    mismatch_count++;
                    $display("%0t: overflowed: expected %0b, actual %0b",
                             $time, want.overflowed, m_overflowed);
                end
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_store();
        test_overflow();
        test_drain_pause();
        test_back_to_back();
        test_random_vectors();
        s_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ssv_pkg.sv
rtl/ssv_ram.sv
rtl/ssv_dp.sv
rtl/ssv_ctrl.sv
rtl/sigma_scale_vector.sv
sim/sigma_scale_vector_tb.sv
